// File: rtl/ansi_c_escape_decoder_core_defines.svh
// assertion macros used by the checker file
`ifndef ANSI_C_ESCAPE_DECODER_CORE_DEFINES_SVH
`define ANSI_C_ESCAPE_DECODER_CORE_DEFINES_SVH

// concurrent check, switched off while reset is held
`define ACED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also runs during reset
`define ACED_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/aced_pkg.sv
package aced_pkg;

  // most decoded bytes one input byte can release
  localparam int MAX_BYTES = 4;
  localparam int BI_W      = $clog2(MAX_BYTES);
  // wide enough for the byte count plus the end marker
  localparam int NB_W      = 3;

  // one decoded request from the front to the back
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [NB_W-1:0]           nbytes;
    logic                      done;
    logic                      status;
  } cmd_t;

endpackage

// File: rtl/aced_front.sv
module aced_front import aced_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_is_last,
  output logic       q_push,
  output cmd_t       q_cmd,
  input  logic       q_full
);

  // decoder modes
  localparam logic [2:0] M_PLAIN   = 3'd0;
  localparam logic [2:0] M_ESC     = 3'd1;
  localparam logic [2:0] M_CTRL    = 3'd2;
  localparam logic [2:0] M_CTRL_BS = 3'd3;
  localparam logic [2:0] M_HEX     = 3'd4;
  localparam logic [2:0] M_OCT     = 3'd5;

  localparam logic [7:0] CH_BS = 8'h5C;
  localparam logic [7:0] CH_C  = 8'h63;
  localparam logic [7:0] CH_X  = 8'h78;

  // result of one decode pass
  typedef struct packed {
    logic [2:0]      mode;
    logic [7:0]      acc;
    logic [1:0]      cnt;
    logic [1:0][7:0] em;
    logic [1:0]      ne;
    logic            again;
  } pass_t;

  // simple escapes, bit 8 flags a match
  function automatic logic [8:0] simple_esc(input logic [7:0] b);
    logic [8:0] r;
    r = '0;
    unique case (b)
      8'h22:   r = {1'b1, 8'h22};
      8'h27:   r = {1'b1, 8'h27};
      8'h5C:   r = {1'b1, 8'h5C};
      8'h61:   r = {1'b1, 8'd7};
      8'h62:   r = {1'b1, 8'd8};
      8'h65:   r = {1'b1, 8'd27};
      8'h66:   r = {1'b1, 8'd12};
      8'h6E:   r = {1'b1, 8'd10};
      8'h72:   r = {1'b1, 8'd13};
      8'h74:   r = {1'b1, 8'd9};
      8'h76:   r = {1'b1, 8'd11};
      default: r = '0;
    endcase
    return r;
  endfunction

  // control code letters and punctuation, bit 8 flags a match
  function automatic logic [8:0] ctrl_code(input logic [7:0] b);
    logic ok;
    ok = (b >= 8'h41 && b <= 8'h5F) || (b >= 8'h61 && b <= 8'h7A) || (b == 8'h3F);
    return {ok, (b == 8'h3F) ? 8'd127 : {3'b000, b[4:0]}};
  endfunction

  // hex digit value, bit 4 flags a match
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

  // one pass of the escape state machine over the current byte
  function automatic pass_t dec_pass(input logic [2:0] md, input logic [7:0] acc,
                                     input logic [1:0] cnt, input logic [7:0] b,
                                     input logic last);
    pass_t      r;
    logic [8:0] sv;
    logic [8:0] cv;
    logic [4:0] hv;
    logic       oct;
    logic [1:0] cnt_inc;
    r       = '0;
    r.mode  = md;
    r.acc   = acc;
    r.cnt   = cnt;
    sv      = simple_esc(b);
    cv      = ctrl_code(b);
    hv      = hex_digit(b);
    oct     = (b >= 8'h30) && (b <= 8'h37);
    cnt_inc = cnt + 2'd1;
    unique case (md)
      M_ESC: begin
        r.mode = M_PLAIN;
        if (sv[8]) begin
          r.em[0] = sv[7:0];
          r.ne    = 2'd1;
        end else if (b == CH_C) begin
          if (last) begin
            r.em[0] = CH_BS;
            r.em[1] = CH_C;
            r.ne    = 2'd2;
          end else begin
            r.mode = M_CTRL;
          end
        end else if (b == CH_X) begin
          if (last) begin
            r.em[0] = CH_BS;
            r.em[1] = CH_X;
            r.ne    = 2'd2;
          end else begin
            r.mode = M_HEX;
            r.acc  = '0;
            r.cnt  = '0;
          end
        end else if (oct) begin
          r.acc = {5'b00000, b[2:0]};
          r.cnt = 2'd1;
          if (last) begin
            r.em[0] = r.acc;
            r.ne    = 2'd1;
          end else begin
            r.mode = M_OCT;
          end
        end else begin
          r.em[0] = CH_BS;
          r.em[1] = b;
          r.ne    = 2'd2;
        end
      end
      M_CTRL: begin
        r.mode = M_PLAIN;
        if (cv[8] && b != CH_BS) begin
          r.em[0] = cv[7:0];
          r.ne    = 2'd1;
        end else if (b == CH_BS && !last) begin
          r.mode = M_CTRL_BS;
        end else begin
          r.em[0] = CH_BS;
          r.em[1] = CH_C;
          r.ne    = 2'd2;
          r.again = 1'b1;
        end
      end
      M_CTRL_BS: begin
        if (b == CH_BS) begin
          r.mode  = M_PLAIN;
          r.em[0] = 8'd28;
          r.ne    = 2'd1;
        end else begin
          // the held backslash opens a new escape
          r.mode  = M_ESC;
          r.em[0] = CH_BS;
          r.em[1] = CH_C;
          r.ne    = 2'd2;
          r.again = 1'b1;
        end
      end
      M_HEX: begin
        if (hv[4]) begin
          r.acc = {acc[3:0], hv[3:0]};
          r.cnt = cnt_inc;
          if (cnt_inc >= 2'd2 || last) begin
            r.mode  = M_PLAIN;
            r.em[0] = r.acc;
            r.ne    = 2'd1;
          end
        end else begin
          r.mode  = M_PLAIN;
          r.again = 1'b1;
          if (cnt == 2'd0) begin
            r.em[0] = CH_BS;
            r.em[1] = CH_X;
            r.ne    = 2'd2;
          end else begin
            r.em[0] = acc;
            r.ne    = 2'd1;
          end
        end
      end
      M_OCT: begin
        if (oct) begin
          r.acc = {acc[4:0], b[2:0]};
          r.cnt = cnt_inc;
          if (cnt_inc == 2'd3 || last) begin
            r.mode  = M_PLAIN;
            r.em[0] = r.acc;
            r.ne    = 2'd1;
          end
        end else begin
          r.mode  = M_PLAIN;
          r.em[0] = acc;
          r.ne    = 2'd1;
          r.again = 1'b1;
        end
      end
      default: begin
        r.mode = M_PLAIN;
        if (b == CH_BS && !last) begin
          r.mode = M_ESC;
        end else begin
          r.em[0] = b;
          r.ne    = 2'd1;
        end
      end
    endcase
    return r;
  endfunction

  logic [2:0] mode_r, mode_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       stop_r, stop_nxt;
  logic       saw_r, saw_nxt;

  logic            accept;
  pass_t           p0, p1, p2, fin;
  logic [5:0][7:0] vals;
  logic [5:0]      vld;
  logic            stopped;
  logic [NB_W-1:0] n;
  logic [MAX_BYTES-1:0][7:0] bytes;
  logic            saw_now;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  // up to three passes, then drop bytes after a decoded nul
  always_comb begin
    p0  = dec_pass(mode_r, acc_r, cnt_r, in_byte, in_is_last);
    p1  = dec_pass(p0.mode, p0.acc, p0.cnt, in_byte, in_is_last);
    p2  = dec_pass(p1.mode, p1.acc, p1.cnt, in_byte, in_is_last);
    fin = p0.again ? (p1.again ? p2 : p1) : p0;

    vals = {p2.em[1], p2.em[0], p1.em[1], p1.em[0], p0.em[1], p0.em[0]};
    vld[0] = p0.ne != 2'd0;
    vld[1] = p0.ne == 2'd2;
    vld[2] = p0.again && (p1.ne != 2'd0);
    vld[3] = p0.again && (p1.ne == 2'd2);
    vld[4] = p0.again && p1.again && (p2.ne != 2'd0);
    vld[5] = p0.again && p1.again && (p2.ne == 2'd2);

    stopped = stop_r;
    n       = '0;
    bytes   = '0;
    for (int i = 0; i < 6; i++) begin
      if (vld[i] && !stopped) begin
        if (vals[i] == 8'd0) begin
          stopped = 1'b1;
        end else begin
          bytes[n[BI_W-1:0]] = vals[i];
          n = n + NB_W'(1);
        end
      end
    end

    saw_now      = saw_r || (in_byte == 8'd0);
    q_cmd.bytes  = bytes;
    q_cmd.nbytes = n;
    q_cmd.done   = in_is_last;
    q_cmd.status = in_is_last && saw_now;
  end

  // decoder state, back to reset after the last byte of a text
  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    stop_nxt = stop_r;
    saw_nxt  = saw_r;
    if (accept) begin
      if (in_is_last) begin
        mode_nxt = M_PLAIN;
        acc_nxt  = '0;
        cnt_nxt  = '0;
        stop_nxt = 1'b0;
        saw_nxt  = 1'b0;
      end else begin
        mode_nxt = fin.mode;
        acc_nxt  = fin.acc;
        cnt_nxt  = fin.cnt;
        stop_nxt = stopped;
        saw_nxt  = saw_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_PLAIN;
      acc_r  <= '0;
      cnt_r  <= '0;
      stop_r <= 1'b0;
      saw_r  <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      stop_r <= stop_nxt;
      saw_r  <= saw_nxt;
    end
  end

endmodule

// File: rtl/aced_queue.sv
module aced_queue import aced_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t rd_cmd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full   = cnt_r == CW'(DEPTH);
  assign valid  = cnt_r != '0;
  assign rd_cmd = mem_r[rd_ptr_r];

  // pointer wrap and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: rtl/aced_back.sv
module aced_back import aced_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_has_byte,
  output logic       out_done_res,
  output logic       out_status
);

  logic [NB_W-1:0] idx_r, idx_nxt;
  logic            ov_r, ov_nxt;
  logic [7:0]      byte_r, byte_nxt;
  logic            has_r, has_nxt;
  logic            done_r, done_nxt;
  logic            st_r, st_nxt;

  logic            load;
  logic            load_pl;
  logic [NB_W-1:0] total;

  assign load  = !ov_r || !out_stall;
  assign total = q_cmd.nbytes + NB_W'(q_cmd.done);

  // walk the head request one result per cycle while out_stall is low, bytes then end marker
  always_comb begin
    q_pop    = 1'b0;
    idx_nxt  = idx_r;
    ov_nxt   = ov_r;
    load_pl  = 1'b0;
    byte_nxt = 8'd0;
    has_nxt  = 1'b0;
    done_nxt = 1'b1;
    st_nxt   = q_cmd.status;
    if (idx_r < q_cmd.nbytes) begin
      byte_nxt = q_cmd.bytes[idx_r[BI_W-1:0]];
      has_nxt  = 1'b1;
      done_nxt = 1'b0;
      st_nxt   = 1'b0;
    end
    if (load) begin
      ov_nxt = 1'b0;
      if (q_valid) begin
        if (total == '0) begin
          q_pop = 1'b1;
        end else begin
          ov_nxt  = 1'b1;
          load_pl = 1'b1;
          if (idx_r == total - NB_W'(1)) begin
            q_pop   = 1'b1;
            idx_nxt = '0;
          end else begin
            idx_nxt = idx_r + NB_W'(1);
          end
        end
      end
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (load_pl) begin
      byte_r <= byte_nxt;
      has_r  <= has_nxt;
      done_r <= done_nxt;
      st_r   <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      ov_r  <= ov_nxt;
    end
  end

  assign out_valid    = ov_r;
  assign out_byte     = byte_r;
  assign out_has_byte = has_r;
  assign out_done_res = done_r;
  assign out_status   = st_r;

endmodule

// File: rtl/ansi_c_escape_decoder_core.sv
// channel   direction  handshake          payload
// in_       input      in_valid/in_stall  in_byte, in_is_last
// out_      output     out_valid/out_stall out_byte, out_has_byte, out_done_res, out_status
//
// a byte is decoded in the cycle it is taken and its request enters the queue
// the back end sends one result per cycle while out_stall is low; a byte may release none
// input is taken every cycle while the QDEPTH-entry request queue has room
// synchronous active-low reset clears decoder state, queue and output valid
// out_stall holds the output register; the queue fills, then in_stall rises
module ansi_c_escape_decoder_core import aced_pkg::*; #(
  parameter int QDEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_is_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_has_byte,
  output logic       out_done_res,
  output logic       out_status
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t wr_cmd;
  cmd_t rd_cmd;

  // escape decoding
  aced_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .in_is_last (in_is_last),
    .q_push     (q_push),
    .q_cmd      (wr_cmd),
    .q_full     (q_full)
  );

  // request queue between decode and output
  aced_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_cmd (wr_cmd),
    .full   (q_full),
    .pop    (q_pop),
    .valid  (q_valid),
    .rd_cmd (rd_cmd)
  );

  // result sequencing
  aced_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_cmd        (rd_cmd),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_has_byte (out_has_byte),
    .out_done_res (out_done_res),
    .out_status   (out_status)
  );

endmodule

// File: rtl/aced_checker.sv
`include "ansi_c_escape_decoder_core_defines.svh"

module aced_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_has_byte,
  input logic       out_done_res,
  input logic       out_status
);

  // a stalled result stays put
  `ACED_ASSERT(a_out_hold, (out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_has_byte) && $stable(out_done_res) && $stable(out_status)), "stalled result changed")

  // each result is either a byte or the end marker
  `ACED_ASSERT(a_kind, (out_valid |-> out_has_byte != out_done_res), "result kind malformed")

  // status and a zero byte only show on the end marker
  `ACED_ASSERT(a_marker, (out_valid && out_has_byte |-> !out_status && out_byte != 8'd0), "byte result carries status or nul")

  // reset empties the output
  `ACED_ASSERT_RST(a_reset, (!rst_n |=> !out_valid), "result valid after reset")

endmodule

bind ansi_c_escape_decoder_core aced_checker u_checker (.*);

// File: tb/testbench.sv
// decoder modes of the predictor
typedef enum logic [2:0] {
  DEC_PLAIN,
  DEC_ESC,
  DEC_CTRL,
  DEC_CTRL_BS,
  DEC_HEX,
  DEC_OCT
} dec_mode_t;

// one decoded result as seen on the out_ channel
typedef struct packed {
  logic [7:0] data;
  logic       has_byte;
  logic       done_res;
  logic       status;
} dec_result_t;

localparam logic [7:0] CH_BSL      = 8'h5C;
localparam logic [7:0] CH_C        = "c";
localparam logic [7:0] CH_X        = "x";
localparam logic [7:0] CODE_ESCAPE = 8'd27;
localparam logic [7:0] CODE_FS     = 8'd28;
localparam logic [7:0] CODE_DEL    = 8'd127;
localparam int         MAX_PER_BYTE = 5;

class decoded_byte_board;
  dec_mode_t   mode;
  logic [7:0]  acc;
  logic [1:0]  digits;
  bit          stopped;
  bit          saw_nul;
  dec_result_t pending_results[$];
  int          step_count;
  int          errors;

  function new();
    errors = 0;
    clear_text();
  endfunction

  function void clear_text();
    mode    = DEC_PLAIN;
    acc     = 8'd0;
    digits  = 2'd0;
    stopped = 1'b0;
    saw_nul = 1'b0;
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  // at most five results leave the block per input byte
  function void push_result(dec_result_t r);
    if (step_count < MAX_PER_BYTE) begin
      pending_results.push_back(r);
      step_count++;
    end
  endfunction

  // a decoded nul silences the rest of the text
  function void emit(logic [7:0] v);
    dec_result_t r;
    if (stopped) return;
    if (v == 8'd0) begin
      stopped = 1'b1;
      return;
    end
    r.data     = v;
    r.has_byte = 1'b1;
    r.done_res = 1'b0;
    r.status   = 1'b0;
    push_result(r);
  endfunction

  function int hex_digit(logic [7:0] b);
    if (b >= "0" && b <= "9") return b - "0";
    if (b >= "a" && b <= "f") return b - "a" + 10;
    if (b >= "A" && b <= "F") return b - "A" + 10;
    return -1;
  endfunction

  function int control_value(logic [7:0] b);
    if (b >= "a" && b <= "z") return b - "a" + 1;
    if (b >= "A" && b <= "Z") return b - "A" + 1;
    case (b)
      "[":    return CODE_ESCAPE;
      CH_BSL: return CODE_FS;
      "]":    return 29;
      "^":    return 30;
      "_":    return 31;
      "?":    return CODE_DEL;
      default: return -1;
    endcase
  endfunction

  function int simple_value(logic [7:0] b);
    case (b)
      "\"":   return "\"";
      "'":    return "'";
      CH_BSL: return CH_BSL;
      "a":    return 7;
      "b":    return 8;
      "e":    return CODE_ESCAPE;
      "f":    return 12;
      "n":    return 10;
      "r":    return 13;
      "t":    return 9;
      "v":    return 11;
      default: return -1;
    endcase
  endfunction

  // one raw byte through the escape state machine, up to three passes
  function void decode_raw(logic [7:0] b, bit last);
    int d;
    bit again;
    for (int pass = 0; pass < 3; pass++) begin
      again = 1'b0;
      case (mode)
        DEC_ESC: begin
          mode = DEC_PLAIN;
          d = simple_value(b);
          if (d >= 0) begin
            emit(8'(d));
          end else if (b == CH_C) begin
            if (last) begin
              emit(CH_BSL);
              emit(CH_C);
            end else mode = DEC_CTRL;
          end else if (b == CH_X) begin
            if (last) begin
              emit(CH_BSL);
              emit(CH_X);
            end else begin
              mode   = DEC_HEX;
              acc    = 8'd0;
              digits = 2'd0;
            end
          end else if (b >= "0" && b <= "7") begin
            acc    = b - "0";
            digits = 2'd1;
            if (last) emit(acc);
            else mode = DEC_OCT;
          end else begin
            emit(CH_BSL);
            emit(b);
          end
        end
        DEC_CTRL: begin
          mode = DEC_PLAIN;
          d = control_value(b);
          if (d >= 0 && b != CH_BSL) begin
            emit(8'(d));
          end else if (b == CH_BSL && !last) begin
            mode = DEC_CTRL_BS;
          end else begin
            emit(CH_BSL);
            emit(CH_C);
            again = 1'b1;
          end
        end
        DEC_CTRL_BS: begin
          if (b == CH_BSL) begin
            mode = DEC_PLAIN;
            emit(CODE_FS);
          end else begin
            // the held backslash opens a fresh escape
            emit(CH_BSL);
            emit(CH_C);
            mode  = DEC_ESC;
            again = 1'b1;
          end
        end
        DEC_HEX: begin
          d = hex_digit(b);
          if (d >= 0) begin
            acc = 8'(acc * 16 + d);
            digits++;
            if (digits >= 2'd2 || last) begin
              mode = DEC_PLAIN;
              emit(acc);
            end
          end else begin
            mode = DEC_PLAIN;
            if (digits == 2'd0) begin
              emit(CH_BSL);
              emit(CH_X);
            end else emit(acc);
            again = 1'b1;
          end
        end
        DEC_OCT: begin
          if (b >= "0" && b <= "7") begin
            acc = 8'(acc * 8 + (b - "0"));
            digits++;
            if (digits == 2'd3 || last) begin
              mode = DEC_PLAIN;
              emit(acc);
            end
          end else begin
            mode = DEC_PLAIN;
            emit(acc);
            again = 1'b1;
          end
        end
        default: begin
          mode = DEC_PLAIN;
          if (b == CH_BSL && !last) mode = DEC_ESC;
          else emit(b);
        end
      endcase
      if (!again) break;
    end
  endfunction

  // accepted input request: predict what it releases
  function void take_raw_byte(logic [7:0] b, bit last);
    dec_result_t r;
    step_count = 0;
    if (b == 8'd0) saw_nul = 1'b1;
    decode_raw(b, last);
    if (last) begin
      r.data     = 8'd0;
      r.has_byte = 1'b0;
      r.done_res = 1'b1;
      r.status   = saw_nul;
      push_result(r);
      clear_text();
    end
  endfunction

  // accepted output request against the oldest prediction
  function void match_result(logic [7:0] data, logic has_byte, logic done_res,
                             logic status);
    dec_result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result byte %02h has %0b done %0b status %0b",
               $time, data, has_byte, done_res, status);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    if (want.data !== data || want.has_byte !== has_byte ||
        want.done_res !== done_res || want.status !== status) begin
      $display("%0t: mismatch expected byte %02h has %0b done %0b status %0b",
               $time, want.data, want.has_byte, want.done_res, want.status);
      $display("%0t:          actual   byte %02h has %0b done %0b status %0b",
               $time, data, has_byte, done_res, status);
      errors++;
    end
  endfunction
endclass

module testbench;
  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'd0;
  logic       in_is_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_has_byte;
  logic       out_done_res;
  logic       out_status;

  decoded_byte_board board = new();
  logic [7:0] text_buf[$];
  bit         calm = 1'b0;
  int         stall_left = 0;
  int         random_sent = 0;
  int         text_idx = 0;

  string simple_set = "\"'\\abefnrtv";
  string ctrl_set   = "azAZmQ[]^_?";
  string bad_ctrl   = "@{1 ";
  string hex_set    = "0123456789abcdefABCDEFgz";
  string oct_set    = "01234567";

  ansi_c_escape_decoder_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_is_last   (in_is_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_has_byte (out_has_byte),
    .out_done_res (out_done_res),
    .out_status   (out_status)
  );

  always #10 clk = ~clk;

  // run limit
  initial begin
    #8000000;
    $display("testbench: done, errors");
    $finish;
  end

  // output back-pressure: mostly open, short stalls, a few long ones
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (calm || $urandom_range(0, 99) < 65) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b1;
      if ($urandom_range(0, 99) < 8) stall_left = $urandom_range(8, 40);
      else stall_left = $urandom_range(0, 2);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.match_result(out_byte, out_has_byte, out_done_res, out_status);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic add_byte(logic [7:0] b);
    text_buf.push_back(b);
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  function automatic logic [7:0] pick_char(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  // send the buffered text, last marker on its final byte
  task automatic send_text();
    int gap;
    bit last;
    for (int i = 0; i < text_buf.size(); i++) begin
      gap  = pick_gap();
      last = (i == text_buf.size() - 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid   <= 1'b1;
      in_byte    <= text_buf[i];
      in_is_last <= last;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      board.take_raw_byte(text_buf[i], last);
      random_sent++;
    end
    text_buf.delete();
  endtask

  // random text: mostly well-formed escapes, some noise and truncation
  task automatic build_random_text();
    int pieces;
    int kind;
    int n;
    if ($urandom_range(0, 99) < 15) begin
      n = $urandom_range(1, 8);
      repeat (n) add_byte(8'($urandom_range(0, 255)));
      return;
    end
    pieces = $urandom_range(1, 6);
    repeat (pieces) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        add_byte(8'($urandom_range(1, 255)));
      end else if (kind < 44) begin
        add_byte(CH_BSL);
        add_byte(pick_char(simple_set));
      end else if (kind < 57) begin
        add_byte(CH_BSL);
        add_byte(CH_C);
        n = $urandom_range(0, 99);
        if (n < 60) add_byte(pick_char(ctrl_set));
        else if (n < 75) add_str("\\\\");
        else if (n < 90) begin
          add_byte(CH_BSL);
          add_byte(8'($urandom_range(0, 255)));
        end else add_byte(pick_char(bad_ctrl));
      end else if (kind < 70) begin
        add_byte(CH_BSL);
        add_byte(CH_X);
        n = $urandom_range(0, 3);
        repeat (n) add_byte(pick_char(hex_set));
      end else if (kind < 83) begin
        add_byte(CH_BSL);
        n = $urandom_range(1, 4);
        repeat (n) add_byte(pick_char(oct_set));
      end else if (kind < 91) begin
        add_byte(CH_BSL);
        add_byte(8'($urandom_range(0, 255)));
      end else if (kind < 95) begin
        n = $urandom_range(0, 2);
        if (n == 0) add_str("\\0");
        else if (n == 1) add_str("\\x00");
        else add_str("\\000");
      end else if (kind < 98) begin
        add_byte(8'd0);
      end else begin
        add_byte(CH_BSL);
      end
    end
    if ($urandom_range(0, 99) < 20) begin
      n = $urandom_range(1, text_buf.size());
      while (text_buf.size() > n) void'(text_buf.pop_back());
    end
  endtask

  // stimulus
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, raw nul, open escapes at end, widest burst
    add_byte(8'd0);
    send_text();
    add_byte(8'hFF);
    send_text();
    add_str("\\e");
    send_text();
    add_str("\\c\\\\");
    send_text();
    add_str("\\x4");
    send_text();
    add_str("\\777");
    send_text();
    add_str("\\q");
    send_text();
    add_str("\\c\\q");
    send_text();
    add_byte(CH_BSL);
    send_text();
    add_str("\\0A");
    send_text();

    // random texts, with calm stretches
    random_sent = 0;
    while (random_sent < 320) begin
      calm = ((text_idx % 12) < 2);
      build_random_text();
      send_text();
      text_idx++;
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    // drain
    while (board.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (board.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl
rtl/aced_pkg.sv
rtl/aced_front.sv
rtl/aced_queue.sv
rtl/aced_back.sv
rtl/ansi_c_escape_decoder_core.sv
rtl/aced_checker.sv
tb/testbench.sv
